// ===== design/w2rgb_pkg.sv =====
package w2rgb_pkg;

	// Fixed field widths.
	localparam int unsigned WAVE_W = 14;
	localparam int unsigned OUT_W = 8;

	// Q0.16 fraction and Q1.16 level formats.
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned LEVEL_W = FRAC_W + 1;
	localparam int unsigned ONE_Q16 = 65536;
	localparam int unsigned HALF_Q16 = 32768;

	// Intensity ramp: 0.3 base and 0.7 slope in Q0.16.
	localparam int unsigned FAC_BASE = 19661;
	localparam int unsigned FAC_SLOPE = 45875;

	// Segment boundaries in whole nanometres.
	localparam int unsigned NM_VIOLET = 380;
	localparam int unsigned NM_FADE_IN_END = 420;
	localparam int unsigned NM_BLUE = 440;
	localparam int unsigned NM_CYAN = 490;
	localparam int unsigned NM_GREEN = 510;
	localparam int unsigned NM_ORANGE = 580;
	localparam int unsigned NM_RED = 645;
	localparam int unsigned NM_FADE_OUT = 700;
	localparam int unsigned NM_VIS_END = 780;

	// Widest segment that needs a fraction.
	localparam int unsigned SEG_W_MAX = 80;

	// Rounded reciprocals 2^32 / width for each segment width.
	localparam int unsigned RECIP_W = 28;
	localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'((64'd4294967296 + 64'd10) / 64'd20);
	localparam logic [RECIP_W-1:0] RECIP_40 = RECIP_W'((64'd4294967296 + 64'd20) / 64'd40);
	localparam logic [RECIP_W-1:0] RECIP_50 = RECIP_W'((64'd4294967296 + 64'd25) / 64'd50);
	localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'((64'd4294967296 + 64'd30) / 64'd60);
	localparam logic [RECIP_W-1:0] RECIP_65 = RECIP_W'((64'd4294967296 + 64'd32) / 64'd65);
	localparam logic [RECIP_W-1:0] RECIP_70 = RECIP_W'((64'd4294967296 + 64'd35) / 64'd70);
	localparam logic [RECIP_W-1:0] RECIP_80 = RECIP_W'((64'd4294967296 + 64'd40) / 64'd80);

	// Hue segment codes.
	localparam logic [2:0] HUE_VIOLET = 3'd0;
	localparam logic [2:0] HUE_BLUE = 3'd1;
	localparam logic [2:0] HUE_CYAN = 3'd2;
	localparam logic [2:0] HUE_GREEN = 3'd3;
	localparam logic [2:0] HUE_ORANGE = 3'd4;
	localparam logic [2:0] HUE_RED = 3'd5;

	// Intensity factor codes.
	localparam logic [1:0] FAC_FLAT = 2'd0;
	localparam logic [1:0] FAC_RISE = 2'd1;
	localparam logic [1:0] FAC_FALL = 2'd2;

	// Depth of the queue between the classifier and the datapath.
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef struct packed {
		logic visible;
		logic [2:0] hue;
		logic [1:0] fac;
	} w2rgb_ctl_t;

endpackage

// ===== design/w2rgb_in_if.sv =====
interface w2rgb_in_if;
	import w2rgb_pkg::*;

	logic valid;
	logic ready;
	logic [WAVE_W-1:0] wavelength;

	modport source(output valid, output wavelength, input ready);
	modport sink(input valid, input wavelength, output ready);
endinterface

// ===== design/w2rgb_out_if.sv =====
interface w2rgb_out_if;
	import w2rgb_pkg::*;

	logic valid;
	logic ready;
	logic [OUT_W-1:0] red;
	logic [OUT_W-1:0] green;
	logic [OUT_W-1:0] blue;
	logic visible;

	modport source(output valid, output red, output green, output blue, output visible,
		input ready);
	modport sink(input valid, input red, input green, input blue, input visible,
		output ready);
endinterface

// ===== design/w2rgb_queue.sv =====
module w2rgb_queue #(
	parameter int unsigned WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             pop_valid
);
	import w2rgb_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push_ok;
	logic pop_ok;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign push_ok = push && push_ready;
	assign pop_ok = pop && pop_valid;

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Occupancy never exceeds the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// A lone push grows the count by exactly one.
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && !pop_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");
endmodule

// ===== design/w2rgb_front.sv =====
module w2rgb_front #(
	parameter int unsigned WAVE_FRAC_BITS = 4,
	parameter int unsigned DW = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	w2rgb_in_if.sink               wave,
	output logic                   item_valid,
	output w2rgb_pkg::w2rgb_ctl_t  item_ctl,
	output logic [DW-1:0]          item_d_hue,
	output logic [DW-1:0]          item_d_fac,
	input  logic                   item_ready
);
	import w2rgb_pkg::*;

	localparam int unsigned SPAN_W = $clog2(NM_VIS_END + 1) + WAVE_FRAC_BITS;
	localparam int unsigned LAM_W = (SPAN_W > WAVE_W) ? SPAN_W : WAVE_W;

	logic [LAM_W-1:0] lam;
	w2rgb_ctl_t ctl_d;
	logic [DW-1:0] d_hue_d;
	logic [DW-1:0] d_fac_d;
	logic vld_s1;
	w2rgb_ctl_t ctl_s1;
	logic [DW-1:0] d_hue_s1;
	logic [DW-1:0] d_fac_s1;

	function automatic logic [LAM_W-1:0] nm(input int unsigned v);
		return LAM_W'(v << WAVE_FRAC_BITS);
	endfunction

	// Classify the wavelength and take its offset into the hue and fade segments.
	always_comb begin
		lam = LAM_W'(wave.wavelength);
		ctl_d = '0;
		d_hue_d = '0;
		d_fac_d = '0;
		if (lam >= nm(NM_VIOLET) && lam < nm(NM_VIS_END)) begin
			ctl_d.visible = 1'b1;
			if (lam < nm(NM_BLUE)) begin
				ctl_d.hue = HUE_VIOLET;
				d_hue_d = DW'(lam - nm(NM_VIOLET));
			end else if (lam < nm(NM_CYAN)) begin
				ctl_d.hue = HUE_BLUE;
				d_hue_d = DW'(lam - nm(NM_BLUE));
			end else if (lam < nm(NM_GREEN)) begin
				ctl_d.hue = HUE_CYAN;
				d_hue_d = DW'(lam - nm(NM_CYAN));
			end else if (lam < nm(NM_ORANGE)) begin
				ctl_d.hue = HUE_GREEN;
				d_hue_d = DW'(lam - nm(NM_GREEN));
			end else if (lam < nm(NM_RED)) begin
				ctl_d.hue = HUE_ORANGE;
				d_hue_d = DW'(lam - nm(NM_ORANGE));
			end else begin
				ctl_d.hue = HUE_RED;
			end
			if (lam < nm(NM_FADE_IN_END)) begin
				ctl_d.fac = FAC_RISE;
				d_fac_d = DW'(lam - nm(NM_VIOLET));
			end else if (lam >= nm(NM_FADE_OUT)) begin
				ctl_d.fac = FAC_FALL;
				d_fac_d = DW'(lam - nm(NM_FADE_OUT));
			end
		end
	end

	// One register stage; it moves on whenever the queue can take its item.
	assign wave.ready = !vld_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (wave.ready) begin
			vld_s1 <= wave.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wave.valid && wave.ready) begin
			ctl_s1 <= ctl_d;
			d_hue_s1 <= d_hue_d;
			d_fac_s1 <= d_fac_d;
		end
	end

	assign item_valid = vld_s1;
	assign item_ctl = ctl_s1;
	assign item_d_hue = d_hue_s1;
	assign item_d_fac = d_fac_s1;

	// A fade segment is only ever chosen for a visible wavelength.
	a_fac_visible: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (ctl_s1.fac != FAC_FLAT) |-> ctl_s1.visible)
		else $error("fade segment on an invisible wavelength");
endmodule

// ===== design/w2rgb_gamma.sv =====
module w2rgb_gamma #(
	parameter int unsigned COLOR_BITS = 8,
	parameter int unsigned GAMMA_TABLE_BITS = 10
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [GAMMA_TABLE_BITS:0]   idx,
	output logic [COLOR_BITS-1:0]       level
);
	localparam int unsigned TBL_SIZE = (1 << GAMMA_TABLE_BITS) + 1;
	localparam int unsigned CMAX = (1 << COLOR_BITS) - 1;
	localparam int unsigned BIG_W = 160;

	logic [COLOR_BITS-1:0] rom [TBL_SIZE];

	// True when v - 0.5 <= CMAX * (i / 2^G)^0.8, compared exactly after raising to the 5th power.
	function automatic logic level_ok(input int unsigned v, input int unsigned i);
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		int k;
		if (v == 0) begin
			return 1'b1;
		end
		lhs = BIG_W'(1);
		rhs = BIG_W'(32);
		for (k = 0; k < 5; k++) begin
			lhs = lhs * BIG_W'(2 * v - 1);
			rhs = rhs * BIG_W'(CMAX);
		end
		for (k = 0; k < 4; k++) begin
			lhs = lhs << GAMMA_TABLE_BITS;
			rhs = rhs * BIG_W'(i);
		end
		return lhs <= rhs;
	endfunction

	// Binary search for the largest level that still rounds down to the curve.
	function automatic logic [COLOR_BITS-1:0] gamma_entry(input int unsigned i);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int k;
		lo = 0;
		hi = CMAX;
		for (k = 0; k <= COLOR_BITS; k++) begin
			if (lo < hi) begin
				mid = lo + ((hi - lo + 1) >> 1);
				if (level_ok(mid, i)) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return COLOR_BITS'(lo);
	endfunction

	// The table contents are fixed when the design is built.
	for (genvar i = 0; i < TBL_SIZE; i++) begin : g_rom
		localparam logic [COLOR_BITS-1:0] ENTRY = gamma_entry(i);
		assign rom[i] = ENTRY;
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (en) begin
			level <= rom[idx];
		end
	end
endmodule

// ===== design/w2rgb_back.sv =====
module w2rgb_back #(
	parameter int unsigned WAVE_FRAC_BITS = 4,
	parameter int unsigned COLOR_BITS = 8,
	parameter int unsigned GAMMA_TABLE_BITS = 10,
	parameter int unsigned DW = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  w2rgb_pkg::w2rgb_ctl_t  item_ctl,
	input  logic [DW-1:0]          item_d_hue,
	input  logic [DW-1:0]          item_d_fac,
	output logic                   item_pop,
	w2rgb_out_if.source            color
);
	import w2rgb_pkg::*;

	localparam int unsigned PW = DW + RECIP_W;
	localparam int unsigned XS_W = PW - FRAC_W - WAVE_FRAC_BITS;
	localparam int unsigned IDX_W = GAMMA_TABLE_BITS + 1;
	localparam int unsigned SC_W = LEVEL_W + GAMMA_TABLE_BITS + 1;
	localparam int unsigned NCH = 3;
	localparam logic [LEVEL_W-1:0] ONE = LEVEL_W'(ONE_Q16);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// Stage 1: reciprocal multiplies.
	logic [RECIP_W-1:0] recip_hue;
	logic [RECIP_W-1:0] recip_fac;
	w2rgb_ctl_t ctl_s1;
	logic [PW-1:0] prod_hue_s1;
	logic [PW-1:0] prod_fac_s1;

	// Stage 2: channel levels and intensity factor.
	logic [FRAC_W-1:0] x_hue;
	logic [FRAC_W-1:0] x_fac;
	logic [31:0] slope_prod;
	logic [FRAC_W-1:0] slope;
	logic [LEVEL_W-1:0] fac_d;
	logic [LEVEL_W-1:0] lvl_d [NCH];
	logic vis_s2;
	logic [LEVEL_W-1:0] lvl_s2 [NCH];
	logic [LEVEL_W-1:0] fac_s2;

	// Stage 3: scaled channels.
	logic [33:0] scaled_prod [NCH];
	logic vis_s3;
	logic [LEVEL_W-1:0] p_s3 [NCH];

	// Stage 4: gamma lookup, also the output register.
	logic [SC_W-1:0] idx_sum [NCH];
	logic [IDX_W-1:0] idx [NCH];
	logic vis_s4;
	logic [COLOR_BITS-1:0] gamma_s4 [NCH];

	function automatic logic [FRAC_W-1:0] to_frac(input logic [PW-1:0] prod);
		logic [XS_W-1:0] xs;
		xs = XS_W'(prod >> (FRAC_W + WAVE_FRAC_BITS));
		return (|xs[XS_W-1:FRAC_W]) ? '1 : xs[FRAC_W-1:0];
	endfunction

	// The whole datapath moves together when the output register is free.
	assign adv = !vld_s4 || color.ready;
	assign item_pop = adv && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Pick the reciprocal of the segment width.
	always_comb begin
		case (item_ctl.hue)
			HUE_VIOLET: recip_hue = RECIP_60;
			HUE_BLUE:   recip_hue = RECIP_50;
			HUE_CYAN:   recip_hue = RECIP_20;
			HUE_GREEN:  recip_hue = RECIP_70;
			HUE_ORANGE: recip_hue = RECIP_65;
			default:    recip_hue = '0;
		endcase
		case (item_ctl.fac)
			FAC_RISE: recip_fac = RECIP_40;
			FAC_FALL: recip_fac = RECIP_80;
			default:  recip_fac = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= item_ctl;
			prod_hue_s1 <= PW'(item_d_hue) * PW'(recip_hue);
			prod_fac_s1 <= PW'(item_d_fac) * PW'(recip_fac);
		end
	end

	// Saturate the fractions, build the channel levels and the fade factor.
	always_comb begin
		x_hue = to_frac(prod_hue_s1);
		x_fac = to_frac(prod_fac_s1);
		slope_prod = 32'(x_fac) * 32'(FAC_SLOPE) + 32'(HALF_Q16);
		slope = slope_prod[31:16];
		case (ctl_s1.fac)
			FAC_RISE: fac_d = LEVEL_W'(FAC_BASE) + LEVEL_W'(slope);
			FAC_FALL: fac_d = ONE - LEVEL_W'(slope);
			default:  fac_d = ONE;
		endcase
		case (ctl_s1.hue)
			HUE_VIOLET: begin
				lvl_d[0] = ONE - LEVEL_W'(x_hue);
				lvl_d[1] = '0;
				lvl_d[2] = ONE;
			end
			HUE_BLUE: begin
				lvl_d[0] = '0;
				lvl_d[1] = LEVEL_W'(x_hue);
				lvl_d[2] = ONE;
			end
			HUE_CYAN: begin
				lvl_d[0] = '0;
				lvl_d[1] = ONE;
				lvl_d[2] = ONE - LEVEL_W'(x_hue);
			end
			HUE_GREEN: begin
				lvl_d[0] = LEVEL_W'(x_hue);
				lvl_d[1] = ONE;
				lvl_d[2] = '0;
			end
			HUE_ORANGE: begin
				lvl_d[0] = ONE;
				lvl_d[1] = ONE - LEVEL_W'(x_hue);
				lvl_d[2] = '0;
			end
			default: begin
				lvl_d[0] = ONE;
				lvl_d[1] = '0;
				lvl_d[2] = '0;
			end
		endcase
		// Outside the visible range every channel is black.
		if (!ctl_s1.visible) begin
			for (int c = 0; c < NCH; c++) begin
				lvl_d[c] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s2 <= ctl_s1.visible;
			fac_s2 <= fac_d;
			for (int c = 0; c < NCH; c++) begin
				lvl_s2[c] <= lvl_d[c];
			end
		end
	end

	// Scale each channel by the factor with rounding.
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			scaled_prod[c] = 34'(lvl_s2[c]) * 34'(fac_s2) + 34'(HALF_Q16);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s3 <= vis_s2;
			for (int c = 0; c < NCH; c++) begin
				p_s3[c] <= scaled_prod[c][32:16];
			end
		end
	end

	// Round each scaled channel to a table index.
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			idx_sum[c] = (SC_W'(p_s3[c]) << GAMMA_TABLE_BITS) + SC_W'(HALF_Q16);
			idx[c] = idx_sum[c][FRAC_W +: IDX_W];
		end
	end

	for (genvar c = 0; c < NCH; c++) begin : g_gamma
		w2rgb_gamma #(
			.COLOR_BITS(COLOR_BITS),
			.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
		) u_gamma (
			.clk(clk),
			.en(adv),
			.idx(idx[c]),
			.level(gamma_s4[c])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s4 <= vis_s3;
		end
	end

	assign color.valid = vld_s4;
	assign color.red = OUT_W'(gamma_s4[0]);
	assign color.green = OUT_W'(gamma_s4[1]);
	assign color.blue = OUT_W'(gamma_s4[2]);
	assign color.visible = vis_s4;

	// An invisible item leaves stage 2 with all channels dark.
	a_dark_levels: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !vis_s2 |-> (lvl_s2[0] == '0 && lvl_s2[1] == '0 && lvl_s2[2] == '0))
		else $error("invisible item carries a channel level");

	// An invisible result is black at the output.
	a_dark_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !vis_s4 |-> (gamma_s4[0] == '0 && gamma_s4[1] == '0 && gamma_s4[2] == '0))
		else $error("invisible result is not black");
endmodule

// ===== design/wavelength_to_rgb_core.sv =====
// Channel   Dir   Payload                          Transaction
// wave      in    wavelength (14 b, Q10.4 nm)      valid && ready
// color     out   red, green, blue (8 b), visible  valid && ready
//
// One wavelength is accepted every clock cycle while ready on wave is high; each wavelength
// passes the front register, the queue, three datapath stages and the gamma table read.
// The gamma table is a constant built at elaboration, so no clearing pass follows reset;
// reset only empties the front register, the queue and the datapath valid flags.
// A stalled color freezes the datapath; the four-entry queue keeps taking wavelengths,
// and ready on wave drops only once the queue and the front register are both full.
module wavelength_to_rgb_core #(
	parameter int unsigned WAVE_FRAC_BITS = 4,
	parameter int unsigned COLOR_BITS = 8,
	parameter int unsigned GAMMA_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	w2rgb_in_if.sink    wave,
	w2rgb_out_if.source color
);
	import w2rgb_pkg::*;

	localparam int unsigned DW = $clog2(SEG_W_MAX) + WAVE_FRAC_BITS;
	localparam int unsigned QW = $bits(w2rgb_ctl_t) + 2 * DW;

	logic front_valid;
	w2rgb_ctl_t front_ctl;
	logic [DW-1:0] front_d_hue;
	logic [DW-1:0] front_d_fac;
	logic front_ready;
	logic q_valid;
	logic q_pop;
	logic [QW-1:0] q_data;
	w2rgb_ctl_t q_ctl;
	logic [DW-1:0] q_d_hue;
	logic [DW-1:0] q_d_fac;

	// Front: classification of each wavelength.
	w2rgb_front #(
		.WAVE_FRAC_BITS(WAVE_FRAC_BITS),
		.DW(DW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.wave(wave),
		.item_valid(front_valid),
		.item_ctl(front_ctl),
		.item_d_hue(front_d_hue),
		.item_d_fac(front_d_fac),
		.item_ready(front_ready)
	);

	// Queue that decouples the front from the datapath.
	w2rgb_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_valid),
		.push_data({front_ctl, front_d_hue, front_d_fac}),
		.push_ready(front_ready),
		.pop(q_pop),
		.pop_data(q_data),
		.pop_valid(q_valid)
	);

	assign {q_ctl, q_d_hue, q_d_fac} = q_data;

	// Back: fractions, factor, scaling and gamma.
	w2rgb_back #(
		.WAVE_FRAC_BITS(WAVE_FRAC_BITS),
		.COLOR_BITS(COLOR_BITS),
		.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS),
		.DW(DW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(q_valid),
		.item_ctl(q_ctl),
		.item_d_hue(q_d_hue),
		.item_d_fac(q_d_fac),
		.item_pop(q_pop),
		.color(color)
	);
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import w2rgb_pkg::*;

	// Core configuration, kept at the defaults of the core.
	localparam int unsigned WAVE_FRAC = 4;
	localparam int unsigned COLOR_DEPTH = 8;
	localparam int unsigned GAMMA_BITS = 10;
	localparam int unsigned LUT_TOP = 1 << GAMMA_BITS;
	localparam int unsigned COLOR_MAX = (1 << COLOR_DEPTH) - 1;

	// Run control.
	localparam int unsigned HOLD_CYCLES = 64;
	localparam int unsigned DRAIN_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
		logic visible;
	} color_t;

	logic clk;
	logic arst_n;

	w2rgb_in_if wave_if();
	w2rgb_out_if color_if();

	wavelength_to_rgb_core #(
		.WAVE_FRAC_BITS(WAVE_FRAC),
		.COLOR_BITS(COLOR_DEPTH),
		.GAMMA_TABLE_BITS(GAMMA_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wave(wave_if),
		.color(color_if)
	);

	logic [OUT_W-1:0] gamma_lut [0:LUT_TOP];
	color_t expected_colors[$];

	bit wave_gaps_on;
	bit color_stalls_on;
	bit hold_color_req;

	int unsigned error_count;
	int unsigned waves_sent;
	int unsigned visible_sent;
	int unsigned wave_wait_cycles;
	int unsigned colors_seen;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the core hangs.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned nm_to_q(int unsigned nm);
		return nm << WAVE_FRAC;
	endfunction

	// Segment and fade boundaries, in nanometres, in ascending order.
	function automatic int unsigned boundary_nm(int unsigned k);
		case (k)
			0: return NM_VIOLET;
			1: return NM_FADE_IN_END;
			2: return NM_BLUE;
			3: return NM_CYAN;
			4: return NM_GREEN;
			5: return NM_ORANGE;
			6: return NM_RED;
			7: return NM_FADE_OUT;
			default: return NM_VIS_END;
		endcase
	endfunction

	// True when v - 0.5 <= COLOR_MAX * (i / LUT_TOP)^0.8, compared exactly as
	// (2v-1)^5 * LUT_TOP^4 <= 32 * COLOR_MAX^5 * i^4.
	function automatic bit gamma_level_fits(int unsigned v, int unsigned i);
		bit [127:0] lhs;
		bit [127:0] rhs;
		int k;
		if (v == 0)
			return 1'b1;
		lhs = 128'd1;
		rhs = 128'd32;
		for (k = 0; k < 5; k++) begin
			lhs = lhs * 128'(2 * v - 1);
			rhs = rhs * 128'(COLOR_MAX);
		end
		for (k = 0; k < 4; k++) begin
			lhs = lhs * 128'(LUT_TOP);
			rhs = rhs * 128'(i);
		end
		return lhs <= rhs;
	endfunction

	// Each gamma entry is the largest level that still fits, found by bisection.
	task automatic build_gamma_lut();
		int unsigned i;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		for (i = 0; i <= LUT_TOP; i++) begin
			lo = 0;
			hi = COLOR_MAX;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				if (gamma_level_fits(mid, i))
					lo = mid;
				else
					hi = mid - 1;
			end
			gamma_lut[i] = OUT_W'(lo);
		end
	endtask

	// Q0.16 position inside a segment, from a rounded reciprocal of its width.
	function automatic int unsigned seg_fraction(int unsigned lam, int unsigned start_nm,
		int unsigned width_nm);
		longint unsigned offset;
		longint unsigned recip;
		longint unsigned frac;
		offset = 64'(lam - nm_to_q(start_nm));
		recip = ((64'd1 << 32) + 64'(width_nm / 2)) / 64'(width_nm);
		frac = (offset * recip) >> (FRAC_W + WAVE_FRAC);
		return (frac > 65535) ? 65535 : int'(frac);
	endfunction

	// The 0.7 slope of the fade ramps, applied to a fraction.
	function automatic int unsigned fade_step(int unsigned frac);
		longint unsigned prod;
		prod = 64'(FAC_SLOPE) * 64'(frac) + 64'(HALF_Q16);
		return int'(prod >> FRAC_W);
	endfunction

	// Scale one channel level by the intensity factor and look up its gamma value.
	function automatic logic [OUT_W-1:0] shaded_level(int unsigned level, int unsigned factor);
		longint unsigned scaled;
		longint unsigned idx;
		scaled = (64'(level) * 64'(factor) + 64'(HALF_Q16)) >> FRAC_W;
		idx = ((scaled << GAMMA_BITS) + 64'(HALF_Q16)) >> FRAC_W;
		if (idx > 64'(LUT_TOP))
			idx = 64'(LUT_TOP);
		return gamma_lut[idx[GAMMA_BITS:0]];
	endfunction

	// Expected color for one wavelength.
	function automatic color_t predict_color(logic [WAVE_W-1:0] wl);
		color_t res;
		int unsigned lam;
		int unsigned frac;
		int unsigned factor;
		int unsigned r_lvl;
		int unsigned g_lvl;
		int unsigned b_lvl;
		logic [2:0] hue;
		lam = 32'(wl);
		res = '0;
		if (lam < nm_to_q(NM_VIOLET) || lam >= nm_to_q(NM_VIS_END))
			return res;

		if (lam < nm_to_q(NM_BLUE))
			hue = HUE_VIOLET;
		else if (lam < nm_to_q(NM_CYAN))
			hue = HUE_BLUE;
		else if (lam < nm_to_q(NM_GREEN))
			hue = HUE_CYAN;
		else if (lam < nm_to_q(NM_ORANGE))
			hue = HUE_GREEN;
		else if (lam < nm_to_q(NM_RED))
			hue = HUE_ORANGE;
		else
			hue = HUE_RED;

		r_lvl = 0;
		g_lvl = 0;
		b_lvl = 0;
		case (hue)
			HUE_VIOLET: begin
				frac = seg_fraction(lam, NM_VIOLET, NM_BLUE - NM_VIOLET);
				r_lvl = ONE_Q16 - frac;
				b_lvl = ONE_Q16;
			end
			HUE_BLUE: begin
				frac = seg_fraction(lam, NM_BLUE, NM_CYAN - NM_BLUE);
				g_lvl = frac;
				b_lvl = ONE_Q16;
			end
			HUE_CYAN: begin
				frac = seg_fraction(lam, NM_CYAN, NM_GREEN - NM_CYAN);
				g_lvl = ONE_Q16;
				b_lvl = ONE_Q16 - frac;
			end
			HUE_GREEN: begin
				frac = seg_fraction(lam, NM_GREEN, NM_ORANGE - NM_GREEN);
				r_lvl = frac;
				g_lvl = ONE_Q16;
			end
			HUE_ORANGE: begin
				frac = seg_fraction(lam, NM_ORANGE, NM_RED - NM_ORANGE);
				r_lvl = ONE_Q16;
				g_lvl = ONE_Q16 - frac;
			end
			default: begin
				r_lvl = ONE_Q16;
			end
		endcase

		// Fade in at the violet end, fade out at the red end.
		factor = ONE_Q16;
		if (lam < nm_to_q(NM_FADE_IN_END))
			factor = FAC_BASE + fade_step(seg_fraction(lam, NM_VIOLET,
				NM_FADE_IN_END - NM_VIOLET));
		else if (lam >= nm_to_q(NM_FADE_OUT))
			factor = ONE_Q16 - fade_step(seg_fraction(lam, NM_FADE_OUT,
				NM_VIS_END - NM_FADE_OUT));

		res.red = shaded_level(r_lvl, factor);
		res.green = shaded_level(g_lvl, factor);
		res.blue = shaded_level(b_lvl, factor);
		res.visible = 1'b1;
		return res;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Mostly visible light, some values close to a boundary, some anywhere.
	function automatic logic [WAVE_W-1:0] random_wavelength();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return WAVE_W'($urandom_range(nm_to_q(NM_VIOLET), nm_to_q(NM_VIS_END) - 1));
		if (roll < 9)
			return WAVE_W'(nm_to_q(boundary_nm($urandom_range(0, 8))) +
				$urandom_range(0, 5) - 3);
		return WAVE_W'($urandom);
	endfunction

	task automatic note_failure(string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("mismatch: %s", msg);
	endtask

	// Offer one wavelength and wait until the core takes it, then maybe pause.
	task automatic send_wave(logic [WAVE_W-1:0] wl);
		color_t want;
		int unsigned gap;
		wave_if.valid <= 1'b1;
		wave_if.wavelength <= wl;
		@(posedge clk);
		while (!wave_if.ready) begin
			wave_wait_cycles++;
			@(posedge clk);
		end
		want = predict_color(wl);
		expected_colors.push_back(want);
		waves_sent++;
		if (want.visible)
			visible_sent++;
		@(negedge clk);
		gap = wave_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			wave_if.valid <= 1'b0;
			wave_if.wavelength <= WAVE_W'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic stop_wave();
		wave_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_colors.size() != 0)
			@(negedge clk);
	endtask

	// Range limits, every boundary on both sides, and alternating bit patterns.
	task automatic test_directed();
		logic [WAVE_W-1:0] probes[$];
		int unsigned k;
		wave_gaps_on = 1'b1;
		color_stalls_on = 1'b1;
		probes.push_back('0);
		probes.push_back('1);
		probes.push_back(WAVE_W'(14'h2AAA));
		probes.push_back(WAVE_W'(14'h1555));
		for (k = 0; k < 9; k++) begin
			probes.push_back(WAVE_W'(nm_to_q(boundary_nm(k)) - 1));
			probes.push_back(WAVE_W'(nm_to_q(boundary_nm(k))));
		end
		probes.push_back(WAVE_W'(nm_to_q(NM_VIOLET) + 1));
		probes.push_back(WAVE_W'(nm_to_q(660) + 9));
		foreach (probes[i])
			send_wave(probes[i]);
	endtask

	// Random visible-heavy traffic with idle gaps on both sides.
	task automatic test_visible_sweep();
		int unsigned n;
		wave_gaps_on = 1'b1;
		color_stalls_on = 1'b1;
		for (n = 0; n < 900; n++)
			send_wave(random_wavelength());
	endtask

	// Back-to-back transactions on both sides, then a pause until all colors are out.
	task automatic test_full_rate();
		int unsigned n;
		wave_gaps_on = 1'b0;
		color_stalls_on = 1'b0;
		for (n = 0; n < 300; n++)
			send_wave(random_wavelength());
		stop_wave();
		wait_drained();
	endtask

	// The color side holds off for a long stretch while wavelengths keep coming,
	// so the queue fills and the core drops ready on the wave side.
	task automatic test_output_hold();
		int unsigned n;
		wave_gaps_on = 1'b0;
		color_stalls_on = 1'b0;
		hold_color_req = 1'b1;
		for (n = 0; n < 200; n++)
			send_wave(random_wavelength());
		stop_wave();
		wait_drained();
	endtask

	// Uniform over the whole input field, mostly out of range.
	task automatic test_full_range();
		int unsigned n;
		wave_gaps_on = 1'b1;
		color_stalls_on = 1'b1;
		for (n = 0; n < 300; n++)
			send_wave(WAVE_W'($urandom));
	endtask

	// Color sink: random stalls, plus the long hold when a test asks for one.
	initial begin : color_sink
		int unsigned stall_left;
		stall_left = 0;
		color_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_color_req) begin
				hold_color_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && color_stalls_on) begin
				stall_left = pick_gap();
			end
			if (stall_left != 0) begin
				color_if.ready <= 1'b0;
				stall_left--;
			end else begin
				color_if.ready <= 1'b1;
			end
		end
	end

	// Compare every color transaction with the oldest expected color.
	always @(posedge clk) begin : color_check
		color_t seen;
		color_t want;
		if (arst_n && color_if.valid && color_if.ready) begin
			seen = {color_if.red, color_if.green, color_if.blue, color_if.visible};
			colors_seen++;
			if (expected_colors.size() == 0) begin
				note_failure($sformatf("unexpected color r=%0d g=%0d b=%0d v=%0b",
					seen.red, seen.green, seen.blue, seen.visible));
			end else begin
				want = expected_colors.pop_front();
				if (seen.red !== want.red || seen.green !== want.green ||
					seen.blue !== want.blue || seen.visible !== want.visible)
					note_failure($sformatf(
						"color %0d: expected r=%0d g=%0d b=%0d v=%0b, got r=%0d g=%0d b=%0d v=%0b",
						colors_seen, want.red, want.green, want.blue, want.visible,
						seen.red, seen.green, seen.blue, seen.visible));
			end
		end
	end

	// Test sequence.
	initial begin : stimulus
		int unsigned waited;
		arst_n = 1'b0;
		wave_if.valid = 1'b0;
		wave_if.wavelength = '0;
		wave_gaps_on = 1'b0;
		color_stalls_on = 1'b0;
		hold_color_req = 1'b0;
		build_gamma_lut();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_visible_sweep();
		test_full_rate();
		test_output_hold();
		test_full_range();
		stop_wave();

		// Let the last colors come out, then watch for strays.
		waited = 0;
		while (expected_colors.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_colors.size() != 0) begin
			error_count++;
			$display("%0d expected colors never arrived", expected_colors.size());
		end

		$display("Sent %0d wavelengths (%0d visible), checked %0d colors.",
			waves_sent, visible_sent, colors_seen);
		$display("Idle gaps, random and long color stalls, full rate; wave side held %0d cycles.",
			wave_wait_cycles);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== wavelength_to_rgb_core.f =====
design/w2rgb_pkg.sv
design/w2rgb_in_if.sv
design/w2rgb_out_if.sv
design/w2rgb_queue.sv
design/w2rgb_front.sv
design/w2rgb_gamma.sv
design/w2rgb_back.sv
design/wavelength_to_rgb_core.sv
tb/sv/tb_top.sv
